[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/ccd_pkg.sv]
// Package: widths, codes and record types of the clock/countdown timer.
`default_nettype none

package ccd_pkg;

    localparam int FUNC_W     = 2;
    localparam int IN_HOURS_W = 5;
    localparam int HOURS_W    = 7;
    localparam int MINUTES_W  = 6;
    localparam int SECONDS_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [SECONDS_W-1:0] SECONDS_MAX = 6'd59;
    localparam logic [MINUTES_W-1:0] MINUTES_MAX = 6'd59;
    localparam logic [HOURS_W-1:0]   HOURS_MAX   = 7'd23;
    localparam logic [HOURS_W-1:0]   HALF_DAY    = 7'd12;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_LOAD      = 2'd1,
        FUNC_RESTART   = 2'd2,
        FUNC_SET_BLINK = 2'd3
    } ccd_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED          = 3'd0,
        REG_COUNT_DOWN       = 3'd1,
        REG_SIGNAL_ONLY      = 3'd2,
        REG_BLINK_SEPARATORS = 3'd3,
        REG_TWENTY_FOUR_HOUR = 3'd4,
        REG_PRESET_HOURS     = 3'd5,
        REG_PRESET_MINUTES   = 3'd6,
        REG_PRESET_SECONDS   = 3'd7
    } ccd_reg_idx_t;

    typedef struct packed {
        logic                 enabled;
        logic                 count_down;
        logic                 signal_only;
        logic                 blink_separators;
        logic                 twenty_four_hour;
        logic [HOURS_W-1:0]   preset_hours;
        logic [MINUTES_W-1:0] preset_minutes;
        logic [SECONDS_W-1:0] preset_seconds;
    } ccd_cfg_t;

    typedef struct packed {
        ccd_func_t             func;
        logic [IN_HOURS_W-1:0] time_hours;
        logic [MINUTES_W-1:0]  time_minutes;
        logic [SECONDS_W-1:0]  time_seconds;
        logic                  blink_value;
    } ccd_cmd_t;

    typedef struct packed {
        logic [HOURS_W-1:0]   count_hours;
        logic [MINUTES_W-1:0] count_minutes;
        logic [SECONDS_W-1:0] count_seconds;
        logic                 blink_flag;
        logic                 digit_phase;
        logic                 colon_phase;
    } ccd_state_t;

    typedef struct packed {
        logic [HOURS_W-1:0]   shown_hours;
        logic [MINUTES_W-1:0] shown_minutes;
        logic [SECONDS_W-1:0] shown_seconds;
        logic                 digits_lit;
        logic                 colons_lit;
        logic                 blinking;
    } ccd_disp_t;

endpackage

`default_nettype wire

[rtl/core/ccd_cmd_if.sv]
// Interface: command channel (valid/ready plus command fields).
`default_nettype none

interface ccd_cmd_if;
    import ccd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [IN_HOURS_W-1:0] time_hours;
    logic [MINUTES_W-1:0]  time_minutes;
    logic [SECONDS_W-1:0]  time_seconds;
    logic                  blink_value;

    modport source (
        output valid, func, time_hours, time_minutes, time_seconds, blink_value,
        input  ready
    );

    modport sink (
        input  valid, func, time_hours, time_minutes, time_seconds, blink_value,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/ccd_disp_if.sv]
// Interface: display result channel (valid/ready plus display fields).
`default_nettype none

interface ccd_disp_if;
    import ccd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HOURS_W-1:0]   shown_hours;
    logic [MINUTES_W-1:0] shown_minutes;
    logic [SECONDS_W-1:0] shown_seconds;
    logic                 digits_lit;
    logic                 colons_lit;
    logic                 blinking;

    modport source (
        output valid, shown_hours, shown_minutes, shown_seconds,
               digits_lit, colons_lit, blinking,
        input  ready
    );

    modport sink (
        input  valid, shown_hours, shown_minutes, shown_seconds,
               digits_lit, colons_lit, blinking,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/clock_countdown_timer.sv]
// Top level of the clock/countdown timer: state, result register, handshakes.
//
//  channel | dir | width | content
//  --------+-----+-------+------------------------------------------------------
//  cmd     | in  | 20    | func, time_hours, time_minutes, time_seconds, blink_value
//  disp    | out | 22    | shown_hours/minutes/seconds, digits_lit, colons_lit, blinking
//  cfg_*   | in  | 1+3+7 | write enable, register index, write data
//
//  One command per cycle unless disp stalls: each transfer on cmd is applied to the
//  time state in the same cycle and its display record appears on disp in the
//  next cycle. The single result register sets the rate; cmd stays ready while that
//  register is empty or being drained, so a stall on disp holds cmd off only
//  while a result is waiting. Reset (rst_n low, asynchronous) clears the time
//  to 00:00:00, the blink flag and colon phase to 0, the digit phase to 1,
//  restores the register defaults and empties the result register.
`default_nettype none

module clock_countdown_timer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [ccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccd_pkg::CFG_DATA_W-1:0] cfg_data,
    ccd_cmd_if.sink                             cmd,
    ccd_disp_if.source                          disp
);
    import ccd_pkg::*;

    ccd_cfg_t   cfg;
    ccd_cmd_t   cmd_word;
    ccd_state_t state_reg;
    ccd_state_t state_next;
    ccd_disp_t  disp_next;
    ccd_disp_t  disp_reg;
    logic       disp_valid_reg;
    logic       cmd_xfer;

    // Configuration registers; write them only while no command is in flight.
    ccd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gather the command fields into one record.
    assign cmd_word.func         = ccd_func_t'(cmd.func);
    assign cmd_word.time_hours   = cmd.time_hours;
    assign cmd_word.time_minutes = cmd.time_minutes;
    assign cmd_word.time_seconds = cmd.time_seconds;
    assign cmd_word.blink_value  = cmd.blink_value;

    // Apply the command to the current state and form the display record.
    ccd_step u_step (
        .cfg  (cfg),
        .cmd  (cmd_word),
        .cur  (state_reg),
        .nxt  (state_next),
        .disp (disp_next)
    );

    // Accept while the result slot is empty or its content leaves this cycle.
    assign cmd.ready = !disp_valid_reg || disp.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    // Advance the time state on every transfer; hold it otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.count_hours   <= '0;
            state_reg.count_minutes <= '0;
            state_reg.count_seconds <= '0;
            state_reg.blink_flag    <= 1'b0;
            state_reg.digit_phase   <= 1'b1;
            state_reg.colon_phase   <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: fill on a transfer, drop the valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_valid_reg <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            disp_valid_reg <= 1'b1;
        end
        else if (disp.ready)
        begin
            disp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            disp_reg <= disp_next;
        end
    end

    assign disp.valid         = disp_valid_reg;
    assign disp.shown_hours   = disp_reg.shown_hours;
    assign disp.shown_minutes = disp_reg.shown_minutes;
    assign disp.shown_seconds = disp_reg.shown_seconds;
    assign disp.digits_lit    = disp_reg.digits_lit;
    assign disp.colons_lit    = disp_reg.colons_lit;
    assign disp.blinking      = disp_reg.blinking;

endmodule

`default_nettype wire

[rtl/core/ccd_cfg_regs.sv]
// Configuration register file of the clock/countdown timer.
`default_nettype none

module ccd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [ccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccd_pkg::CFG_DATA_W-1:0] cfg_data,
    output ccd_pkg::ccd_cfg_t                   cfg
);
    import ccd_pkg::*;

    ccd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled          <= 1'b1;
            cfg_reg.count_down       <= 1'b0;
            cfg_reg.signal_only      <= 1'b1;
            cfg_reg.blink_separators <= 1'b0;
            cfg_reg.twenty_four_hour <= 1'b1;
            cfg_reg.preset_hours     <= '0;
            cfg_reg.preset_minutes   <= '0;
            cfg_reg.preset_seconds   <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (ccd_reg_idx_t'(cfg_index))
                REG_ENABLED:          cfg_reg.enabled          <= cfg_data[0];
                REG_COUNT_DOWN:       cfg_reg.count_down       <= cfg_data[0];
                REG_SIGNAL_ONLY:      cfg_reg.signal_only      <= cfg_data[0];
                REG_BLINK_SEPARATORS: cfg_reg.blink_separators <= cfg_data[0];
                REG_TWENTY_FOUR_HOUR: cfg_reg.twenty_four_hour <= cfg_data[0];
                REG_PRESET_HOURS:     cfg_reg.preset_hours     <= cfg_data[HOURS_W-1:0];
                REG_PRESET_MINUTES:   cfg_reg.preset_minutes   <= cfg_data[MINUTES_W-1:0];
                REG_PRESET_SECONDS:   cfg_reg.preset_seconds   <= cfg_data[SECONDS_W-1:0];
                default:              cfg_reg.enabled          <= cfg_reg.enabled;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/ccd_step.sv]
// Next-state and display logic for one command of the clock/countdown timer.
`default_nettype none

module ccd_step (
    input  wire ccd_pkg::ccd_cfg_t   cfg,
    input  wire ccd_pkg::ccd_cmd_t   cmd,
    input  wire ccd_pkg::ccd_state_t cur,
    output ccd_pkg::ccd_state_t      nxt,
    output ccd_pkg::ccd_disp_t       disp
);
    import ccd_pkg::*;

    // Count up: each field wraps to zero above its limit, carrying upward.
    logic [SECONDS_W:0]   sec_inc;
    logic                 sec_wrap;
    logic [MINUTES_W:0]   min_inc;
    logic                 min_wrap;
    logic [HOURS_W:0]     hr_inc;
    logic [SECONDS_W-1:0] up_sec;
    logic [MINUTES_W-1:0] up_min;
    logic [HOURS_W-1:0]   up_hr;

    // Count down: borrow through seconds and minutes.
    logic                 sec_zero;
    logic                 min_zero;
    logic                 at_zero;
    logic [SECONDS_W-1:0] down_sec;
    logic [MINUTES_W-1:0] down_min;
    logic [HOURS_W-1:0]   down_hr;

    assign sec_inc  = {1'b0, cur.count_seconds} + (SECONDS_W+1)'(1);
    assign sec_wrap = sec_inc > {1'b0, SECONDS_MAX};
    assign up_sec   = sec_wrap ? '0 : sec_inc[SECONDS_W-1:0];
    assign min_inc  = {1'b0, cur.count_minutes} + (MINUTES_W+1)'(sec_wrap);
    assign min_wrap = min_inc > {1'b0, MINUTES_MAX};
    assign up_min   = min_wrap ? '0 : min_inc[MINUTES_W-1:0];
    assign hr_inc   = {1'b0, cur.count_hours} + (HOURS_W+1)'(min_wrap);
    assign up_hr    = (hr_inc > {1'b0, HOURS_MAX}) ? '0 : hr_inc[HOURS_W-1:0];

    assign sec_zero = (cur.count_seconds == '0);
    assign min_zero = (cur.count_minutes == '0);
    assign at_zero  = sec_zero && min_zero && (cur.count_hours == '0);
    assign down_sec = sec_zero ? SECONDS_MAX : cur.count_seconds - SECONDS_W'(1);
    assign down_min = !sec_zero ? cur.count_minutes :
                      (min_zero ? MINUTES_MAX : cur.count_minutes - MINUTES_W'(1));
    assign down_hr  = (sec_zero && min_zero) ? cur.count_hours - HOURS_W'(1)
                                             : cur.count_hours;

    always_comb
    begin
        nxt = cur;
        unique case (cmd.func)
            FUNC_TICK:
            begin
                if (cfg.enabled)
                begin
                    nxt.colon_phase = cfg.blink_separators ? ~cur.colon_phase : 1'b1;
                    nxt.digit_phase = cur.blink_flag ? ~cur.digit_phase : 1'b1;
                    if (cfg.count_down)
                    begin
                        if (at_zero)
                        begin
                            nxt.blink_flag = 1'b1;
                        end
                        else
                        begin
                            nxt.count_hours   = down_hr;
                            nxt.count_minutes = down_min;
                            nxt.count_seconds = down_sec;
                        end
                    end
                    else if (cfg.signal_only)
                    begin
                        nxt.count_hours   = HOURS_W'(cmd.time_hours);
                        nxt.count_minutes = cmd.time_minutes;
                        nxt.count_seconds = cmd.time_seconds;
                    end
                    else
                    begin
                        nxt.count_hours   = up_hr;
                        nxt.count_minutes = up_min;
                        nxt.count_seconds = up_sec;
                    end
                end
            end
            FUNC_LOAD:
            begin
                if (!cfg.count_down)
                begin
                    nxt.count_hours   = HOURS_W'(cmd.time_hours);
                    nxt.count_minutes = cmd.time_minutes;
                    nxt.count_seconds = cmd.time_seconds;
                end
            end
            FUNC_RESTART:
            begin
                nxt.count_hours   = cfg.preset_hours;
                nxt.count_minutes = cfg.preset_minutes;
                nxt.count_seconds = cfg.preset_seconds;
            end
            FUNC_SET_BLINK:
            begin
                nxt.blink_flag  = cmd.blink_value;
                nxt.digit_phase = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        // Blank the digits whenever the block is disabled.
        nxt.digit_phase = nxt.digit_phase & cfg.enabled;
    end

    always_comb
    begin
        if (!cfg.twenty_four_hour && !cfg.count_down && (nxt.count_hours > HALF_DAY))
        begin
            disp.shown_hours = nxt.count_hours - HALF_DAY;
        end
        else
        begin
            disp.shown_hours = nxt.count_hours;
        end
        disp.shown_minutes = nxt.count_minutes;
        disp.shown_seconds = nxt.count_seconds;
        disp.digits_lit    = nxt.digit_phase;
        disp.colons_lit    = nxt.colon_phase;
        disp.blinking      = nxt.blink_flag;
    end

endmodule

`default_nettype wire

[rtl/core/ccd_checker.sv]
// Port-level checker for the clock/countdown timer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module ccd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic disp_valid,
    input wire logic disp_ready
);

    // A waiting result stays offered until taken.
    `ASSERT_NEXT(a_disp_hold, disp_valid && !disp_ready, disp_valid)

    // An empty result slot never blocks commands.
    `ASSERT_SAME(a_ready_when_empty, !disp_valid, cmd_ready)

    // Every command transfer yields a result in the next cycle.
    `ASSERT_NEXT(a_result_follows, cmd_valid && cmd_ready, disp_valid)

    // A result only appears after a command transfer.
    `ASSERT_SAME(a_no_stray_result, $rose(disp_valid), $past(cmd_valid && cmd_ready))

endmodule

bind clock_countdown_timer ccd_checker u_ccd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .disp_valid (disp.valid),
    .disp_ready (disp.ready)
);

`default_nettype wire
